>>> hw/rtl/mcf_pkg.sv
// Package for the min-cost flow engine: sizes, field widths, command,
// status and register codes. No dependencies.
package mcf_pkg;
  localparam int unsigned NODES  = 64;
  localparam int unsigned ARCS   = 512;
  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned ARC_W  = $clog2(ARCS);
  localparam int unsigned LINK_W = ARC_W + 1;
  localparam int unsigned CAP_W  = 16;
  localparam int unsigned WGT_W  = 17;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned FLOW_W = 24;
  localparam int unsigned COST_W = 48;
  localparam int unsigned HOP_W  = NODE_W + 1;
  localparam int unsigned CNT_W  = ARC_W + 1;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_SHORT = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 104;
endpackage

>>> hw/rtl/min_cost_flow_spfa_engine.sv
// Min-cost flow engine top level: arc store, SPFA search sequencer, augment walk.
// Depends on mcf_pkg.
//
// channel  direction  transfer when            contents
// s_axis   in         tvalid & tready          tuser: cmd; tdata: nodes, capacity, cost, index
// m_axis   out        tvalid & tready          tuser: status; tdata: slot, residual, flow, cost
// cfg      in         cfg_valid_i & cfg_ready_o  index 0 source, 1 sink, 2 flow limit
//
// Add, read and clear each end with the output transfer.
// Solve: each search pops the queue and scans the arcs of each popped node; each path found
// is then walked hop by hop; a final limit check ends the solve.
// The single-port arc and node memories are used in turn by one sequencer.
// Reset empties the graph at once (per-node valid bits); no clearing pass.
// Input is held off while an item is in work, including while its result waits for the output register to free.
module min_cost_flow_spfa_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: from_node[5:0], to_node[11:6], capacity[27:12], arc_cost[43:28], arc_index[52:44]
  input  logic [mcf_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: arc_slot[8:0], residual[24:9], total_flow[48:25], total_cost[96:49]
  output logic [mcf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [mcf_pkg::FLOW_W-1:0]          cfg_data_i
);
  localparam int unsigned NW = mcf_pkg::NODE_W;
  localparam int unsigned AW = mcf_pkg::ARC_W;
  localparam int unsigned LW = mcf_pkg::LINK_W;
  localparam int unsigned CW = mcf_pkg::CAP_W;
  localparam int unsigned WW = mcf_pkg::WGT_W;
  localparam int unsigned DW = mcf_pkg::DIST_W;
  localparam int unsigned FW = mcf_pkg::FLOW_W;
  localparam int unsigned KW = mcf_pkg::COST_W;
  localparam int unsigned HW = mcf_pkg::HOP_W;
  localparam int unsigned NCW = mcf_pkg::CNT_W;
  localparam int unsigned PW = FW + 1 + DW;
  localparam int unsigned SW = PW + 1;
  localparam logic [LW-1:0] LINK_END = LW'(mcf_pkg::ARCS);
  localparam logic signed [SW-1:0] COST_HI = SW'({1'b0, {(KW-1){1'b1}}});
  localparam logic signed [SW-1:0] COST_LO = -COST_HI - SW'(1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ADD0  = 5'd1;
  localparam logic [4:0] S_ADD1  = 5'd2;
  localparam logic [4:0] S_ADD2  = 5'd3;
  localparam logic [4:0] S_RD0   = 5'd4;
  localparam logic [4:0] S_RD1   = 5'd5;
  localparam logic [4:0] S_TOP   = 5'd6;
  localparam logic [4:0] S_INIT  = 5'd7;
  localparam logic [4:0] S_POP   = 5'd8;
  localparam logic [4:0] S_POP1  = 5'd9;
  localparam logic [4:0] S_POP2  = 5'd10;
  localparam logic [4:0] S_ARC   = 5'd11;
  localparam logic [4:0] S_ARC1  = 5'd12;
  localparam logic [4:0] S_ARC2  = 5'd13;
  localparam logic [4:0] S_AUG0  = 5'd14;
  localparam logic [4:0] S_AUG1  = 5'd15;
  localparam logic [4:0] S_WALK  = 5'd16;
  localparam logic [4:0] S_WALK1 = 5'd17;
  localparam logic [4:0] S_WALK2 = 5'd18;
  localparam logic [4:0] S_WALK3 = 5'd19;
  localparam logic [4:0] S_MUL   = 5'd20;
  localparam logic [4:0] S_ACC   = 5'd21;
  localparam logic [4:0] S_END   = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  // memories
  logic [NW-1:0]        tgt_mem   [mcf_pkg::ARCS];
  logic [LW-1:0]        link_mem  [mcf_pkg::ARCS];
  logic signed [WW-1:0] wgt_mem   [mcf_pkg::ARCS];
  logic [CW-1:0]        res_mem   [mcf_pkg::ARCS];
  logic [AW-1:0]        first_mem [mcf_pkg::NODES];
  logic signed [DW-1:0] dist_mem  [mcf_pkg::NODES];
  logic [HW-1:0]        hops_mem  [mcf_pkg::NODES];
  logic [AW-1:0]        par_mem   [mcf_pkg::NODES];
  logic [CW:0]          bn_mem    [mcf_pkg::NODES];
  logic [NW-1:0]        q_mem     [mcf_pkg::NODES];

  logic [NW-1:0] tgt_rd;  logic [LW-1:0] link_rd;  logic signed [WW-1:0] wgt_rd;
  logic [CW-1:0] res_rd;  logic [AW-1:0] first_rd; logic signed [DW-1:0] dist_rd;
  logic [HW-1:0] hops_rd; logic [AW-1:0] par_rd;   logic [CW:0] bn_rd;
  logic [NW-1:0] q_rd;

  logic [4:0] state_q, state_d;
  logic [NW-1:0] src_q, snk_q;
  logic [FW-1:0] limit_q;
  logic [1:0] cmd_q;
  logic [NW-1:0] from_q, to_q;
  logic [CW-1:0] cap_q, cst_q;
  logic [AW-1:0] idx_q;
  logic [NCW-1:0] cnt_q;
  logic [mcf_pkg::NODES-1:0] fvld_q, reached_q, queued_q;
  logic [NW-1:0] head_q, u_q, v_q, k_q;
  logic [NW:0] qcnt_q, steps_q;
  logic [LW-1:0] a_q, lnk_q;
  logic signed [WW-1:0] w_q;
  logic [CW-1:0] r_q;
  logic signed [DW-1:0] du_q, dt_q;
  logic [HW-1:0] hu_q;
  logic [CW:0] bu_q;
  logic [AW-1:0] pa_q;
  logic [FW-1:0] left_q, flow_q, push_q, last_flow_q;
  logic signed [KW-1:0] cost_q, last_cost_q;
  logic signed [PW-1:0] prod_q;
  logic [1:0] rstat_q;
  logic [AW-1:0] rslot_q;
  logic [CW-1:0] rres_q;
  logic ovld_q;
  logic [1:0] ostat_q;
  logic [mcf_pkg::OUT_DATA_W-1:0] odata_q;

  logic in_acc;
  logic signed [DW-1:0] nd;
  logic [CW:0] nb;
  logic [HW-1:0] hn;
  logic signed [SW-1:0] sum;
  logic [FW-1:0] push_new;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser = ostat_q;
  assign m_axis_tdata = odata_q;

  assign nd = du_q + DW'(w_q);
  assign hn = hu_q + HW'(1);
  assign nb = bu_q[CW] ? {1'b0, r_q} : ((bu_q[CW-1:0] < r_q) ? bu_q : {1'b0, r_q});
  assign sum = SW'(cost_q) + SW'(prod_q);
  always_comb begin
    if (bn_rd[CW]) begin
      push_new = left_q;
    end else if (FW'(bn_rd[CW-1:0]) < left_q) begin
      push_new = FW'(bn_rd[CW-1:0]);
    end else begin
      push_new = left_q;
    end
  end

  // arc store
  logic [AW-1:0] arc_ra, res_ra, tgt_ra, arc_wa, res_wa;
  logic arc_we, res_we;
  logic [NW-1:0] tgt_wd;
  logic [LW-1:0] link_wd;
  logic signed [WW-1:0] wgt_wd;
  logic [CW-1:0] res_wd;
  logic [LW-1:0] link_y;

  assign link_y = (to_q == from_q) ? LW'(cnt_q[AW-1:0]) :
                  (fvld_q[to_q] ? {1'b0, first_rd} : LINK_END);

  always_comb begin
    arc_ra = a_q[AW-1:0];
    res_ra = a_q[AW-1:0];
    tgt_ra = a_q[AW-1:0];
    arc_we = 1'b0;
    arc_wa = cnt_q[AW-1:0];
    tgt_wd = to_q;
    link_wd = fvld_q[from_q] ? {1'b0, first_rd} : LINK_END;
    wgt_wd = WW'($signed(cst_q));
    res_we = 1'b0;
    res_wa = cnt_q[AW-1:0];
    res_wd = cap_q;
    case (state_q)
      S_ADD1: begin
        arc_we = 1'b1;
        res_we = 1'b1;
      end
      S_ADD2: begin
        arc_we = 1'b1;
        arc_wa = cnt_q[AW-1:0] | AW'(1);
        tgt_wd = from_q;
        link_wd = link_y;
        wgt_wd = -WW'($signed(cst_q));
        res_we = 1'b1;
        res_wa = cnt_q[AW-1:0] | AW'(1);
        res_wd = '0;
      end
      S_RD0: res_ra = idx_q;
      S_WALK1: begin
        res_ra = par_rd;
        tgt_ra = par_rd ^ AW'(1);
      end
      S_WALK2: begin
        res_ra = pa_q ^ AW'(1);
        res_we = 1'b1;
        res_wa = pa_q;
        res_wd = res_rd - push_q[CW-1:0];
      end
      S_WALK3: begin
        res_we = 1'b1;
        res_wa = pa_q ^ AW'(1);
        res_wd = res_rd + push_q[CW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (arc_we) begin
      tgt_mem[arc_wa] <= tgt_wd;
      link_mem[arc_wa] <= link_wd;
      wgt_mem[arc_wa] <= wgt_wd;
    end
    if (res_we) res_mem[res_wa] <= res_wd;
    tgt_rd <= tgt_mem[tgt_ra];
    link_rd <= link_mem[arc_ra];
    wgt_rd <= wgt_mem[arc_ra];
    res_rd <= res_mem[res_ra];
  end

  // node store
  logic [NW-1:0] first_ra, first_wa, node_ra, node_wa, par_ra, q_ra, q_wa;
  logic first_we, node_we, par_we, q_we;
  logic signed [DW-1:0] dist_wd;
  logic [HW-1:0] hops_wd;
  logic [CW:0] bn_wd;
  logic [NW-1:0] q_wd;
  logic [AW-1:0] first_wd;

  always_comb begin
    first_ra = q_rd;
    first_we = 1'b0;
    first_wa = from_q;
    first_wd = cnt_q[AW-1:0];
    node_ra = q_rd;
    node_we = 1'b0;
    node_wa = v_q;
    dist_wd = nd;
    hops_wd = hn;
    bn_wd = nb;
    par_we = 1'b0;
    par_ra = k_q;
    q_ra = head_q;
    q_we = 1'b0;
    q_wa = head_q + qcnt_q[NW-1:0];
    q_wd = v_q;
    case (state_q)
      S_ADD0: first_ra = from_q;
      S_ADD1: begin
        first_ra = to_q;
        first_we = 1'b1;
      end
      S_ADD2: begin
        first_we = 1'b1;
        first_wa = to_q;
        first_wd = cnt_q[AW-1:0] | AW'(1);
      end
      S_INIT: begin
        node_we = 1'b1;
        node_wa = src_q;
        dist_wd = '0;
        hops_wd = '0;
        bn_wd = {1'b1, {CW{1'b0}}};
        q_we = 1'b1;
        q_wa = '0;
        q_wd = src_q;
      end
      S_ARC1: node_ra = tgt_rd;
      S_ARC2: begin
        if (!(reached_q[v_q] && nd >= dist_rd)) begin
          node_we = 1'b1;
          par_we = 1'b1;
          q_we = !queued_q[v_q] && !qcnt_q[NW] && (hn < HW'(mcf_pkg::NODES));
        end
      end
      S_AUG0: node_ra = snk_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    if (node_we) begin
      dist_mem[node_wa] <= dist_wd;
      hops_mem[node_wa] <= hops_wd;
      bn_mem[node_wa] <= bn_wd;
    end
    if (par_we) par_mem[v_q] <= a_q[AW-1:0];
    if (q_we) q_mem[q_wa] <= q_wd;
    first_rd <= first_mem[first_ra];
    dist_rd <= dist_mem[node_ra];
    hops_rd <= hops_mem[node_ra];
    bn_rd <= bn_mem[node_ra];
    par_rd <= par_mem[par_ra];
    q_rd <= q_mem[q_ra];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            mcf_pkg::CMD_ADD: begin
              if ((NCW + 1)'(cnt_q) + (NCW + 1)'(2) > (NCW + 1)'(mcf_pkg::ARCS)) begin
                state_d = S_DONE;
              end else begin
                state_d = S_ADD0;
              end
            end
            mcf_pkg::CMD_SOLVE: state_d = S_TOP;
            mcf_pkg::CMD_READ:  state_d = S_RD0;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_ADD0: state_d = S_ADD1;
      S_ADD1: state_d = S_ADD2;
      S_ADD2: state_d = S_DONE;
      S_RD0: state_d = (NCW'(idx_q) < cnt_q) ? S_RD1 : S_DONE;
      S_RD1: state_d = S_DONE;
      S_TOP: state_d = (left_q == '0) ? S_END : S_INIT;
      S_INIT: state_d = S_POP;
      S_POP: begin
        if (qcnt_q == '0) begin
          state_d = reached_q[snk_q] ? S_AUG0 : S_END;
        end else begin
          state_d = S_POP1;
        end
      end
      S_POP1: state_d = S_POP2;
      S_POP2: state_d = S_ARC;
      S_ARC: state_d = a_q[AW] ? S_POP : S_ARC1;
      S_ARC1: state_d = (res_rd == '0) ? S_ARC : S_ARC2;
      S_ARC2: begin
        if (!(reached_q[v_q] && nd >= dist_rd) && hn >= HW'(mcf_pkg::NODES)) begin
          state_d = S_END;
        end else begin
          state_d = S_ARC;
        end
      end
      S_AUG0: state_d = S_AUG1;
      S_AUG1: state_d = S_WALK;
      S_WALK: state_d = (k_q == src_q || steps_q[NW]) ? S_MUL : S_WALK1;
      S_WALK1: state_d = S_WALK2;
      S_WALK2: state_d = S_WALK3;
      S_WALK3: state_d = S_WALK;
      S_MUL: state_d = S_ACC;
      S_ACC: state_d = S_TOP;
      S_END: state_d = S_DONE;
      S_DONE: state_d = (!ovld_q || m_axis_tready) ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      src_q <= '0;
      snk_q <= NW'(1);
      limit_q <= '0;
      cnt_q <= '0;
      fvld_q <= '0;
      reached_q <= '0;
      queued_q <= '0;
      head_q <= '0;
      qcnt_q <= '0;
      last_flow_q <= '0;
      last_cost_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mcf_pkg::REG_SOURCE: src_q <= cfg_data_i[NW-1:0];
          mcf_pkg::REG_SINK:   snk_q <= cfg_data_i[NW-1:0];
          mcf_pkg::REG_LIMIT:  limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_DONE && (!ovld_q || m_axis_tready)) begin
        ovld_q <= 1'b1;
      end else if (ovld_q && m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser == mcf_pkg::CMD_CLEAR) begin
            cnt_q <= '0;
            fvld_q <= '0;
            last_flow_q <= '0;
            last_cost_q <= '0;
          end
        end
        S_ADD1: fvld_q[from_q] <= 1'b1;
        S_ADD2: begin
          fvld_q[to_q] <= 1'b1;
          cnt_q <= cnt_q + NCW'(2);
        end
        S_INIT: begin
          reached_q <= {{(mcf_pkg::NODES-1){1'b0}}, 1'b1} << src_q;
          queued_q <= {{(mcf_pkg::NODES-1){1'b0}}, 1'b1} << src_q;
          head_q <= '0;
          qcnt_q <= (NW + 1)'(1);
        end
        S_POP1: begin
          head_q <= head_q + NW'(1);
          qcnt_q <= qcnt_q - (NW + 1)'(1);
          queued_q[q_rd] <= 1'b0;
        end
        S_ARC2: begin
          if (!(reached_q[v_q] && nd >= dist_rd)) begin
            reached_q[v_q] <= 1'b1;
            if (q_we) begin
              queued_q[v_q] <= 1'b1;
              qcnt_q <= qcnt_q + (NW + 1)'(1);
            end
          end
        end
        S_END: begin
          last_flow_q <= flow_q;
          last_cost_q <= cost_q;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q <= s_axis_tuser;
          from_q <= s_axis_tdata[5:0];
          to_q <= s_axis_tdata[11:6];
          cap_q <= s_axis_tdata[27:12];
          cst_q <= s_axis_tdata[43:28];
          idx_q <= s_axis_tdata[52:44];
          rstat_q <= (s_axis_tuser == mcf_pkg::CMD_ADD) ? mcf_pkg::STAT_FULL : mcf_pkg::STAT_OK;
          rslot_q <= '0;
          rres_q <= '0;
          left_q <= limit_q;
          flow_q <= '0;
          cost_q <= '0;
        end
      end
      S_ADD2: begin
        rstat_q <= mcf_pkg::STAT_OK;
        rslot_q <= cnt_q[AW-1:0];
      end
      S_RD1: rres_q <= res_rd;
      S_POP1: u_q <= q_rd;
      S_POP2: begin
        du_q <= dist_rd;
        hu_q <= hops_rd;
        bu_q <= bn_rd;
        a_q <= fvld_q[u_q] ? {1'b0, first_rd} : LINK_END;
      end
      S_ARC1: begin
        v_q <= tgt_rd;
        lnk_q <= link_rd;
        w_q <= wgt_rd;
        r_q <= res_rd;
        if (res_rd == '0) a_q <= link_rd;
      end
      S_ARC2: begin
        a_q <= lnk_q;
        if (!(reached_q[v_q] && nd >= dist_rd) && v_q == u_q) begin
          du_q <= nd;
          hu_q <= hn;
          bu_q <= nb;
        end
      end
      S_AUG1: begin
        push_q <= push_new;
        dt_q <= dist_rd;
        k_q <= snk_q;
        steps_q <= '0;
      end
      S_WALK1: pa_q <= par_rd;
      S_WALK2: k_q <= tgt_rd;
      S_WALK3: steps_q <= steps_q + (NW + 1)'(1);
      S_MUL: prod_q <= $signed({1'b0, push_q}) * dt_q;
      S_ACC: begin
        left_q <= left_q - push_q;
        flow_q <= flow_q + push_q;
        if (sum > COST_HI) begin
          cost_q <= KW'(COST_HI);
        end else if (sum < COST_LO) begin
          cost_q <= KW'(COST_LO);
        end else begin
          cost_q <= KW'(sum);
        end
      end
      S_END: begin
        if (cmd_q == mcf_pkg::CMD_SOLVE) begin
          rstat_q <= (flow_q < limit_q) ? mcf_pkg::STAT_SHORT : mcf_pkg::STAT_OK;
        end
      end
      S_DONE: begin
        if (!ovld_q || m_axis_tready) begin
          ostat_q <= rstat_q;
          odata_q <= {7'd0, last_cost_q, last_flow_q, rres_q, rslot_q};
        end
      end
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/mcf_checker.sv
// Port-level checker for the min-cost flow engine, bound to the top level.
// Depends on mcf_pkg.
module mcf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mcf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("undefined status");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == mcf_pkg::STAT_FULL |-> m_axis_tdata[8:0] == 9'd0)
    else $error("slot given on full store");
endmodule

bind min_cost_flow_spfa_engine mcf_checker u_mcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> dv/testbench.sv
// Testbench for min_cost_flow_spfa_engine: drives add, solve, read and clear
// transfers and checks each result against an in-bench min-cost flow predictor.
// Depends on mcf_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench;
  localparam int unsigned WATCHDOG_LIMIT = 2000000;
  localparam logic [47:0] COST_HI = 48'h7fff_ffff_ffff;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] cost;
    logic [23:0] flow;
    logic [15:0] residual;
    logic [8:0]  slot;
  } mcf_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mcf_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mcf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [mcf_pkg::FLOW_W-1:0] cfg_data_i = '0;

  min_cost_flow_spfa_engine dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [5:0]  src_q, snk_q;
  logic [23:0] limit_q;
  logic [5:0]  a_tgt [mcf_pkg::ARCS];
  int          a_link [mcf_pkg::ARCS];
  int          a_wgt [mcf_pkg::ARCS];
  int unsigned a_res [mcf_pkg::ARCS];
  int          n_first [mcf_pkg::NODES];
  longint      n_dist [mcf_pkg::NODES];
  bit          n_reach [mcf_pkg::NODES];
  int          n_hops [mcf_pkg::NODES];
  bit          n_inq [mcf_pkg::NODES];
  int          n_par [mcf_pkg::NODES];
  int unsigned n_bot [mcf_pkg::NODES];
  int          wq [mcf_pkg::NODES];
  int unsigned arc_cnt;
  int unsigned flow_q;
  longint      cost_q;

  mcf_result_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  function automatic void graph_clear();
    arc_cnt = 0;
    for (int i = 0; i < mcf_pkg::NODES; i++) n_first[i] = mcf_pkg::ARCS;
    flow_q = 0;
    cost_q = 0;
  endfunction

  function automatic bit path_search(int s, int t);
    int qh, qc, u, v, a;
    longint nd;
    qh = 0;
    qc = 1;
    for (int i = 0; i < mcf_pkg::NODES; i++) begin
      n_reach[i] = 0;
      n_inq[i] = 0;
    end
    n_reach[s] = 1; n_dist[s] = 0; n_hops[s] = 0;
    n_bot[s] = 32'h7fffffff; n_inq[s] = 1; wq[0] = s;
    while (qc > 0) begin
      u = wq[qh];
      qh = (qh + 1) % mcf_pkg::NODES;
      qc--;
      n_inq[u] = 0;
      for (a = n_first[u]; a < mcf_pkg::ARCS; a = a_link[a]) begin
        v = a_tgt[a];
        if (a_res[a] == 0) continue;
        nd = n_dist[u] + a_wgt[a];
        if (n_reach[v] && nd >= n_dist[v]) continue;
        n_reach[v] = 1;
        n_dist[v] = nd;
        n_par[v] = a;
        n_hops[v] = n_hops[u] + 1;
        if (n_hops[v] >= mcf_pkg::NODES) return 0;
        n_bot[v] = (n_bot[u] < a_res[a]) ? n_bot[u] : a_res[a];
        if (!n_inq[v] && qc < mcf_pkg::NODES) begin
          n_inq[v] = 1;
          wq[(qh + qc) % mcf_pkg::NODES] = v;
          qc++;
        end
      end
    end
    return n_reach[t];
  endfunction

  function automatic void flow_solve();
    int s, t, k, steps, a;
    int unsigned left, push, fl;
    longint cst;
    s = src_q; t = snk_q; left = limit_q; fl = 0; cst = 0;
    while (left > 0 && path_search(s, t)) begin
      push = (n_bot[t] < left) ? n_bot[t] : left;
      k = t; steps = 0;
      while (k != s && steps < mcf_pkg::NODES) begin
        a = n_par[k];
        a_res[a] -= push;
        a_res[a ^ 1] += push;
        k = a_tgt[a ^ 1];
        steps++;
      end
      left -= push;
      fl += push;
      cst += longint'(push) * n_dist[t];
      if (cst > longint'(COST_HI)) cst = longint'(COST_HI);
      if (cst < -longint'(COST_HI) - 1) cst = -longint'(COST_HI) - 1;
    end
    flow_q = fl;
    cost_q = cst;
  endfunction

  function automatic mcf_result_t predict_item(logic [1:0] cmd, logic [5:0] x,
                                               logic [5:0] y, logic [15:0] cap,
                                               logic [15:0] c, logic [8:0] idx);
    mcf_result_t r;
    r = '0;
    case (cmd)
      mcf_pkg::CMD_ADD: begin
        if (arc_cnt + 2 > mcf_pkg::ARCS) r.status = mcf_pkg::STAT_FULL;
        else begin
          a_tgt[arc_cnt] = y; a_wgt[arc_cnt] = $signed(c); a_res[arc_cnt] = cap;
          a_link[arc_cnt] = n_first[x]; n_first[x] = arc_cnt;
          a_tgt[arc_cnt+1] = x; a_wgt[arc_cnt+1] = -$signed(c); a_res[arc_cnt+1] = 0;
          a_link[arc_cnt+1] = n_first[y]; n_first[y] = arc_cnt + 1;
          r.slot = 9'(arc_cnt);
          arc_cnt += 2;
        end
      end
      mcf_pkg::CMD_SOLVE: begin
        flow_solve();
        r.status = (flow_q < limit_q) ? mcf_pkg::STAT_SHORT : mcf_pkg::STAT_OK;
      end
      mcf_pkg::CMD_READ: if (idx < arc_cnt) r.residual = 16'(a_res[idx]);
      default: graph_clear();
    endcase
    r.flow = 24'(flow_q);
    r.cost = cost_q[47:0];
    return r;
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [5:0] x, logic [5:0] y,
                           logic [15:0] cap, logic [15:0] c, logic [8:0] idx);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b0, idx, c, cap, y, x};
    expected_q.push_back(predict_item(cmd, x, y, cap, c, idx));
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mcf_pkg::REG_SOURCE: src_q = val[5:0];
      mcf_pkg::REG_SINK:   snk_q = val[5:0];
      default:             limit_q = val;
    endcase
  endtask

  task automatic add_arc(int x, int y, int cap, int c);
    send_item(mcf_pkg::CMD_ADD, 6'(x), 6'(y), 16'(cap), 16'(c), 9'($urandom));
  endtask

  // receiver
  always @(posedge clk_i) begin
    mcf_result_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[96:0]};
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status !== exp_r.status)
            $display("%0t status exp %0d got %0d", $time, exp_r.status, got.status);
          if (got.slot !== exp_r.slot)
            $display("%0t arc_slot exp %0d got %0d", $time, exp_r.slot, got.slot);
          if (got.residual !== exp_r.residual)
            $display("%0t residual exp %0d got %0d", $time, exp_r.residual, got.residual);
          if (got.flow !== exp_r.flow)
            $display("%0t total_flow exp %0d got %0d", $time, exp_r.flow, got.flow);
          if (got.cost !== exp_r.cost)
            $display("%0t total_cost exp %h got %h", $time, exp_r.cost, got.cost);
          if (got !== exp_r) errors++;
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    write_reg(mcf_pkg::REG_LIMIT, 24'hffffff);
    add_arc(0, 2, 16'hffff, 3);
    add_arc(2, 1, 10, 16'h8000);
    add_arc(0, 1, 5, 16'h7fff);
    add_arc(63, 0, 0, 0);
    send_item(mcf_pkg::CMD_READ, 0, 0, 0, 0, 9'd3);
    send_item(mcf_pkg::CMD_READ, 0, 0, 0, 0, 9'h1ff);
    send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_item(mcf_pkg::CMD_READ, 0, 0, 0, 0, 9'(i));
    write_reg(mcf_pkg::REG_SINK, 0);
    send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
    send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    // negative cycle
    add_arc(0, 3, 4, 16'hfff0);
    add_arc(3, 0, 4, 16'hfff0);
    add_arc(3, 1, 4, 1);
    write_reg(mcf_pkg::REG_SINK, 1);
    send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
    send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic test_store_full();
    for (int i = 0; i < mcf_pkg::ARCS / 2 + 2; i++)
      add_arc($urandom, $urandom, $urandom, $urandom);
    send_item(mcf_pkg::CMD_READ, 0, 0, 0, 0, 9'h1ff);
    write_reg(mcf_pkg::REG_SOURCE, 63);
    write_reg(mcf_pkg::REG_SINK, 5);
    write_reg(mcf_pkg::REG_LIMIT, 1000);
    send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
    send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++) add_arc(i, i + 1, 100 + i, i);
    join
    while (expected_q.size() != 0) @(posedge clk_i);
    send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
    while (expected_q.size() != 0) @(posedge clk_i);
    send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int items);
    int n, r;
    for (int k = 0; k < items; k += n + 2) begin
      n = $urandom_range(3, 14);
      write_reg(mcf_pkg::REG_SOURCE, 24'($urandom_range(0, 7)));
      write_reg(mcf_pkg::REG_SINK, 24'($urandom_range(0, 7)));
      r = $urandom_range(2);
      write_reg(mcf_pkg::REG_LIMIT,
                24'(r == 0 ? 0 : (r == 1 ? $urandom_range(1, 300) : $urandom)));
      for (int i = 0; i < n; i++)
        add_arc($urandom_range(0, 7), $urandom_range(0, 7),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 60),
                $urandom_range(4) == 0 ? $urandom : $urandom_range(0, 40) - 5);
      send_item(mcf_pkg::CMD_SOLVE, 0, 0, 0, 0, 0);
      send_item(mcf_pkg::CMD_READ, 0, 0, 0, 0,
                9'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 2*n)));
      if ($urandom_range(1)) send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    end
    send_item(mcf_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
  endtask

  initial begin
    src_q = 0; snk_q = 1; limit_q = 0;
    graph_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_backpressure();
    send_idle_pct = 23; recv_idle_pct = 88;
    test_random(35);
    send_idle_pct = 88; recv_idle_pct = 23;
    test_random(35);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(35);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
